[rtl/core/ecr_pkg.sv]
// shared constants and tables for the elevation colour ramp
`default_nettype none

package ecr_pkg;

	localparam int FRACTION_BITS_DEF = 16;

	localparam int PITCH_W    = 17;
	localparam int CHAN_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// clamped pitch range, 0 to 90 degrees in 1/256 degree units
	localparam logic [14:0] PITCH_FULL = 15'd23040;

	localparam logic [1:0] MODE_SINGLE    = 2'd0;
	localparam logic [1:0] MODE_GRADIENT  = 2'd1;
	localparam logic [1:0] MODE_REALISTIC = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_A    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_B    = 2'd2;

	// realistic ramp: segment start positions and lengths
	localparam logic [14:0] SEG_BASE [4] = '{15'd0, 15'd3456, 15'd8064, 15'd13824};
	localparam logic [14:0] SEG_LEN  [4] = '{15'd3456, 15'd4608, 15'd5760, 15'd9216};

	localparam logic [7:0] STOP_RGB [5][3] = '{
		'{8'd255, 8'd100, 8'd40},
		'{8'd255, 8'd160, 8'd80},
		'{8'd255, 8'd220, 8'd150},
		'{8'd255, 8'd245, 8'd220},
		'{8'd255, 8'd253, 8'd245}
	};

endpackage

`default_nettype wire

[rtl/core/ecr_if.sv]
// channel interfaces of the elevation colour ramp
`default_nettype none

interface ecr_angle_if import ecr_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [PITCH_W-1:0] pitch;

	modport source (output valid, output pitch, input ready);
	modport sink (input valid, input pitch, output ready);
endinterface

interface ecr_color_if import ecr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic [CHAN_W-1:0] alpha;

	modport source (output valid, output red, output green, output blue, output alpha,
		input ready);
	modport sink (input valid, input red, input green, input blue, input alpha,
		output ready);
endinterface

interface ecr_cfg_if import ecr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/elevation_color_ramp.sv]
// pitch to rgba colour ramp, pipelined evaluator
//
//  channel | dir | payload                  | beat when
//  --------+-----+--------------------------+------------------------
//  angle   | in  | pitch                    | angle.valid && angle.ready
//  color   | out | red, green, blue, alpha  | color.valid && color.ready
//  cfg     | in  | index, data              | cfg.valid (ready tied high)
//
// one beat per cycle sustained while color.ready stays high
// the elevation divide retires up to four quotient bits per stage over FRACTION_BITS + 1 bits
// reset clears the config registers to zero and empties every stage
// each stage holds while the one after it is full and stalled; bubbles close up
`default_nettype none

module elevation_color_ramp import ecr_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	ecr_angle_if.sink   angle,
	ecr_color_if.source color,
	ecr_cfg_if.sink     cfg
);

	localparam int QW         = FRACTION_BITS + 1;
	localparam int TW         = FRACTION_BITS + 2;
	localparam int SQW        = 2 * QW;
	localparam int PW         = QW + TW;
	localparam int AW         = FRACTION_BITS + 12;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = (QW + DIV_STEPS - 1) / DIV_STEPS;

	localparam logic [QW-1:0]  ONE     = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam logic [TW-1:0]  THREE   = TW'(3) << FRACTION_BITS;
	localparam logic [SQW-1:0] HALF_SQ = SQW'(1) << (FRACTION_BITS - 1);
	localparam logic [PW-1:0]  HALF_W  = PW'(1) << (FRACTION_BITS - 1);
	localparam logic [AW-1:0]  HALF_A  = AW'(1) << (FRACTION_BITS - 1);

	// config registers
	logic [1:0]  mode_q;
	logic [31:0] color_a_q;
	logic [31:0] color_b_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_SINGLE;
			color_a_q <= '0;
			color_b_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_COLOR_MODE: mode_q    <= cfg.data[1:0];
				REG_COLOR_A:    color_a_q <= cfg.data;
				REG_COLOR_B:    color_b_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// pipeline registers
	logic              v_s1;
	logic [14:0]       num_s1;
	logic [14:0]       den_s1;
	logic [1:0]        seg_s1;
	logic [1:0]        mode_s1;

	logic              vld_s2  [DIV_STAGES];
	logic [15:0]       rem_s2  [DIV_STAGES];
	logic [QW-1:0]     quo_s2  [DIV_STAGES];
	logic [14:0]       den_s2  [DIV_STAGES];
	logic [1:0]        seg_s2  [DIV_STAGES];
	logic [1:0]        mode_s2 [DIV_STAGES];

	logic              v_s3;
	logic [QW-1:0]     e_s3;
	logic [1:0]        seg_s3;
	logic [1:0]        mode_s3;

	logic              v_s4;
	logic [QW-1:0]     e_s4;
	logic [QW-1:0]     e2_s4;
	logic [1:0]        seg_s4;
	logic [1:0]        mode_s4;

	logic              v_s5;
	logic [TW-1:0]     w_s5;
	logic [CHAN_W-1:0] c0_s5 [4];
	logic [CHAN_W-1:0] c1_s5 [4];

	logic              v_s6;
	logic [CHAN_W-1:0] chan_s6 [4];

	// stage enables, back to front
	logic en_s1;
	logic en_s2 [DIV_STAGES];
	logic en_s3;
	logic en_s4;
	logic en_s5;
	logic en_s6;

	always_comb begin
		logic chain;
		en_s6 = !v_s6 || color.ready;
		en_s5 = !v_s5 || en_s6;
		en_s4 = !v_s4 || en_s5;
		en_s3 = !v_s3 || en_s4;
		chain = en_s3;
		for (int g = DIV_STAGES - 1; g >= 0; g--) begin
			en_s2[g] = !vld_s2[g] || chain;
			chain    = en_s2[g];
		end
		en_s1 = !v_s1 || chain;
	end

	assign angle.ready = en_s1;

	// stage 1: clamp, segment pick, numerator and divisor
	logic [14:0] p_c;
	logic [1:0]  seg_c;
	logic [14:0] num_c;
	logic [14:0] den_c;

	always_comb begin
		if (angle.pitch[PITCH_W-1]) begin
			p_c = '0;
		end else if (angle.pitch[PITCH_W-2:0] > 16'(PITCH_FULL)) begin
			p_c = PITCH_FULL;
		end else begin
			p_c = angle.pitch[14:0];
		end
		// a pitch on an inner stop stays in the lower segment
		seg_c = '0;
		for (int s = 1; s < 4; s++) begin
			if (p_c > SEG_BASE[s]) begin
				seg_c = 2'(s);
			end
		end
		if (mode_q == MODE_REALISTIC) begin
			num_c = p_c - SEG_BASE[seg_c];
			den_c = SEG_LEN[seg_c];
		end else begin
			num_c = p_c;
			den_c = PITCH_FULL;
		end
	end

	// stage 2: restoring divide, quotient bits shift in msb first
	logic          vld_in  [DIV_STAGES];
	logic [15:0]   rem_in  [DIV_STAGES];
	logic [QW-1:0] quo_in  [DIV_STAGES];
	logic [14:0]   den_in  [DIV_STAGES];
	logic [1:0]    seg_in  [DIV_STAGES];
	logic [1:0]    mode_in [DIV_STAGES];
	logic [15:0]   rem_nx  [DIV_STAGES];
	logic [QW-1:0] quo_nx  [DIV_STAGES];

	always_comb begin
		vld_in[0]  = v_s1;
		rem_in[0]  = {1'b0, num_s1};
		quo_in[0]  = '0;
		den_in[0]  = den_s1;
		seg_in[0]  = seg_s1;
		mode_in[0] = mode_s1;
		for (int g = 1; g < DIV_STAGES; g++) begin
			vld_in[g]  = vld_s2[g-1];
			rem_in[g]  = rem_s2[g-1];
			quo_in[g]  = quo_s2[g-1];
			den_in[g]  = den_s2[g-1];
			seg_in[g]  = seg_s2[g-1];
			mode_in[g] = mode_s2[g-1];
		end
	end

	always_comb begin
		logic [15:0]   r;
		logic [QW-1:0] q;
		for (int g = 0; g < DIV_STAGES; g++) begin
			r = rem_in[g];
			q = quo_in[g];
			for (int j = 0; j < DIV_STEPS; j++) begin
				if (g * DIV_STEPS + j <= FRACTION_BITS) begin
					// the first step takes the integer bit, so no shift there
					if (g * DIV_STEPS + j != 0) begin
						r = {r[14:0], 1'b0};
					end
					if (r >= {1'b0, den_in[g]}) begin
						r = r - {1'b0, den_in[g]};
						q = {q[QW-2:0], 1'b1};
					end else begin
						q = {q[QW-2:0], 1'b0};
					end
				end
			end
			rem_nx[g] = r;
			quo_nx[g] = q;
		end
	end

	// stage 3: round the quotient to nearest
	logic [QW-1:0] e_c;

	always_comb begin
		e_c = quo_s2[DIV_STAGES-1];
		if (rem_s2[DIV_STAGES-1] + 16'(den_s2[DIV_STAGES-1] >> 1) >=
				16'(den_s2[DIV_STAGES-1])) begin
			e_c = e_c + QW'(1);
		end
	end

	// stage 4: e squared
	logic [SQW-1:0] sq_c;
	assign sq_c = SQW'(e_s3) * SQW'(e_s3) + HALF_SQ;

	// stage 5: smoothstep weight and channel end values
	logic [TW-1:0]     thr_c;
	logic [PW-1:0]     wp_c;
	logic [CHAN_W-1:0] c0_c [4];
	logic [CHAN_W-1:0] c1_c [4];

	assign thr_c = THREE - {e_s4, 1'b0};
	assign wp_c  = PW'(e2_s4) * PW'(thr_c) + HALF_W;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			case (mode_s4)
				MODE_GRADIENT: begin
					c0_c[k] = color_a_q[31 - 8 * k -: 8];
					c1_c[k] = color_b_q[31 - 8 * k -: 8];
				end
				MODE_REALISTIC: begin
					if (k < 3) begin
						c0_c[k] = STOP_RGB[seg_s4][k];
						c1_c[k] = STOP_RGB[3'(seg_s4) + 3'd1][k];
					end else begin
						c0_c[k] = 8'hFF;
						c1_c[k] = 8'hFF;
					end
				end
				// single colour and the unused code: equal ends give color_a
				default: begin
					c0_c[k] = color_a_q[31 - 8 * k -: 8];
					c1_c[k] = color_a_q[31 - 8 * k -: 8];
				end
			endcase
		end
	end

	// stage 6: per-channel blend lanes
	logic [CHAN_W-1:0] chan_c [4];

	always_comb begin
		logic signed [8:0]    dlt;
		logic signed [TW:0]   ws;
		logic signed [AW-1:0] acc;
		ws = $signed({1'b0, w_s5});
		for (int k = 0; k < 4; k++) begin
			dlt = $signed({1'b0, c1_s5[k]}) - $signed({1'b0, c0_s5[k]});
			acc = $signed(AW'({c0_s5[k], {FRACTION_BITS{1'b0}}})) + AW'(dlt) * AW'(ws)
				+ $signed(HALF_A);
			chan_c[k] = acc[FRACTION_BITS +: CHAN_W];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int g = 0; g < DIV_STAGES; g++) begin
				vld_s2[g] <= 1'b0;
			end
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= angle.valid;
			end
			for (int g = 0; g < DIV_STAGES; g++) begin
				if (en_s2[g]) begin
					vld_s2[g] <= vld_in[g];
				end
			end
			if (en_s3) begin
				v_s3 <= vld_s2[DIV_STAGES-1];
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
			if (en_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en_s1) begin
			num_s1  <= num_c;
			den_s1  <= den_c;
			seg_s1  <= seg_c;
			mode_s1 <= mode_q;
		end
		for (int g = 0; g < DIV_STAGES; g++) begin
			if (en_s2[g]) begin
				rem_s2[g]  <= rem_nx[g];
				quo_s2[g]  <= quo_nx[g];
				den_s2[g]  <= den_in[g];
				seg_s2[g]  <= seg_in[g];
				mode_s2[g] <= mode_in[g];
			end
		end
		if (en_s3) begin
			e_s3    <= e_c;
			seg_s3  <= seg_s2[DIV_STAGES-1];
			mode_s3 <= mode_s2[DIV_STAGES-1];
		end
		if (en_s4) begin
			e_s4    <= e_s3;
			e2_s4   <= sq_c[FRACTION_BITS +: QW];
			seg_s4  <= seg_s3;
			mode_s4 <= mode_s3;
		end
		if (en_s5) begin
			w_s5 <= wp_c[FRACTION_BITS +: TW];
			for (int k = 0; k < 4; k++) begin
				c0_s5[k] <= c0_c[k];
				c1_s5[k] <= c1_c[k];
			end
		end
		if (en_s6) begin
			for (int k = 0; k < 4; k++) begin
				chan_s6[k] <= chan_c[k];
			end
		end
	end

	assign color.valid = v_s6;
	assign color.red   = chan_s6[0];
	assign color.green = chan_s6[1];
	assign color.blue  = chan_s6[2];
	assign color.alpha = chan_s6[3];

	// the input only stalls behind a full first stage
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!angle.ready |-> v_s1)
		else $error("input stalled with an empty first stage");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2[DIV_STAGES-1] |-> rem_s2[DIV_STAGES-1] < {1'b0, den_s2[DIV_STAGES-1]})
		else $error("divide remainder not below divisor");

	a_elev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> e_s3 <= ONE)
		else $error("elevation above one");

	a_weight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> w_s5 <= TW'(ONE))
		else $error("smoothstep weight above one");

endmodule

`default_nettype wire
